// ----- sv/nec_ir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared types, register indexes, reset values and window helpers.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

  localparam int FRAME_BITS_DEFAULT = 32;
  localparam int TIME_W = 32;
  localparam int WIN_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0] LEADER_MIN_RESET = 16'd12800;
  localparam logic [WIN_W-1:0] LEADER_MAX_RESET = 16'd14000;
  localparam logic [WIN_W-1:0] ONE_MIN_RESET = 16'd2250;
  localparam logic [WIN_W-1:0] ONE_MAX_RESET = 16'd2488;
  localparam logic [BYTE_W-1:0] EXPECTED_ADDRESS_RESET = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_MIN = 3'd0,
    REG_LEADER_MAX = 3'd1,
    REG_ONE_MIN = 3'd2,
    REG_ONE_MAX = 3'd3,
    REG_EXPECTED_ADDRESS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [WIN_W-1:0] leader_min_us;
    logic [WIN_W-1:0] leader_max_us;
    logic [WIN_W-1:0] one_min_us;
    logic [WIN_W-1:0] one_max_us;
    logic [BYTE_W-1:0] expected_address;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] address_copy;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] command_inverse;
    logic frame_ok;
  } result_t;

  // True when value lies strictly between lo and hi. An empty window never hits.
  function automatic logic window_hit(input logic [TIME_W-1:0] value,
                                      input logic [WIN_W-1:0] lo,
                                      input logic [WIN_W-1:0] hi);
    window_hit = (value > TIME_W'(lo)) && (value < TIME_W'(hi));
  endfunction

endpackage

// ----- sv/nec_ir_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR configuration registers
// Holds the timing windows and the expected address; writes past the list are dropped.
// ----------------------------------------------------------------------------
module nec_ir_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [nec_ir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nec_ir_pkg::CFG_DATA_W-1:0]     cfg_data,
  output nec_ir_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min_us <= nec_ir_pkg::LEADER_MIN_RESET;
      cfg.leader_max_us <= nec_ir_pkg::LEADER_MAX_RESET;
      cfg.one_min_us <= nec_ir_pkg::ONE_MIN_RESET;
      cfg.one_max_us <= nec_ir_pkg::ONE_MAX_RESET;
      cfg.expected_address <= nec_ir_pkg::EXPECTED_ADDRESS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nec_ir_pkg::REG_LEADER_MIN: cfg.leader_min_us <= cfg_data;
        nec_ir_pkg::REG_LEADER_MAX: cfg.leader_max_us <= cfg_data;
        nec_ir_pkg::REG_ONE_MIN: cfg.one_min_us <= cfg_data;
        nec_ir_pkg::REG_ONE_MAX: cfg.one_max_us <= cfg_data;
        nec_ir_pkg::REG_EXPECTED_ADDRESS: begin
          cfg.expected_address <= cfg_data[nec_ir_pkg::BYTE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/nec_ir_frame_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame core
// Measures edge intervals, classifies them and collects bits into a frame.
// ----------------------------------------------------------------------------
module nec_ir_frame_core #(
  parameter int FRAME_BITS = nec_ir_pkg::FRAME_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [nec_ir_pkg::TIME_W-1:0]     edge_time_us,
  input  nec_ir_pkg::cfg_t                  cfg,
  output logic                              done,
  output nec_ir_pkg::result_t               result
);

  localparam int CNT_W = $clog2(FRAME_BITS);
  localparam logic [CNT_W:0] FRAME_END = (CNT_W + 1)'(FRAME_BITS);

  logic                           started;
  logic [nec_ir_pkg::TIME_W-1:0]  last_time;
  logic [CNT_W-1:0]               count;
  logic [FRAME_BITS-1:0]          shift;

  logic [nec_ir_pkg::TIME_W-1:0]  interval;
  logic                           is_leader;
  logic                           is_one;
  logic [CNT_W:0]                 count_inc;
  logic                           frame_end;
  logic [FRAME_BITS-1:0]          shift_set;
  logic [nec_ir_pkg::TIME_W-1:0]  frame_word;

  // The interval wraps with the free-running counter.
  assign interval = edge_time_us - last_time;
  assign is_leader = nec_ir_pkg::window_hit(interval, cfg.leader_min_us, cfg.leader_max_us);
  assign is_one = nec_ir_pkg::window_hit(interval, cfg.one_min_us, cfg.one_max_us);
  assign count_inc = {1'b0, count} + 1'b1;
  assign frame_end = (count_inc == FRAME_END);

  always_comb begin
    shift_set = shift;
    shift_set[count] = is_one;
  end

  assign frame_word = nec_ir_pkg::TIME_W'(shift_set);
  assign done = step && started && !is_leader && frame_end;

  always_comb begin
    result.address = frame_word[7:0];
    result.address_copy = frame_word[15:8];
    result.command = frame_word[23:16];
    result.command_inverse = frame_word[31:24];
    result.frame_ok = (frame_word[7:0] == cfg.expected_address) &&
                      (frame_word[15:8] == frame_word[7:0]) &&
                      (~frame_word[23:16] == frame_word[31:24]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      last_time <= '0;
      count <= '0;
      shift <= '0;
    end else if (step) begin
      last_time <= edge_time_us;
      if (!started) begin
        started <= 1'b1;
      end else if (is_leader) begin
        count <= '0;
        shift <= '0;
      end else if (frame_end) begin
        started <= 1'b0;
        count <= '0;
        shift <= '0;
      end else begin
        count <= count_inc[CNT_W-1:0];
        shift <= shift_set;
      end
    end
  end

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    done |=> !started)
    else $error("frame core still started after a completed frame");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} < FRAME_END)
    else $error("bit count reached the frame length");

  a_leader_clears: assert property (@(posedge clk) disable iff (rst)
    (step && started && is_leader) |=> (count == '0 && shift == '0))
    else $error("leader did not clear the collected bits");

endmodule

// ----- sv/nec_ir_frame_decoder.sv -----
`timescale 1ns / 1ps
// Flow: an accepted edge waits in the input register until the core takes it; the
// combinational interval compare and bit insert feed the registered frame result.
// Throughput: one edge per cycle unless a stalled pending result blocks the core.
// Reset: synchronous, active high; clears the pipeline, the frame state and loads the
// default timing windows and expected address.
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Decodes NEC infrared frames from timestamped falling-edge events.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder #(
  parameter int FRAME_BITS = nec_ir_pkg::FRAME_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port.
  input  logic                                  cfg_write,
  input  logic [nec_ir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nec_ir_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Edge event channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [nec_ir_pkg::TIME_W-1:0]         edge_time_us,
  // Frame result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [nec_ir_pkg::BYTE_W-1:0]         address,
  output logic [nec_ir_pkg::BYTE_W-1:0]         address_copy,
  output logic [nec_ir_pkg::BYTE_W-1:0]         command,
  output logic [nec_ir_pkg::BYTE_W-1:0]         command_inverse,
  output logic                                  frame_ok
);

  nec_ir_pkg::cfg_t     cfg;
  nec_ir_pkg::result_t  core_result;
  logic                 core_done;

  // Input register: holds one edge time until the core can take it.
  logic                           in_full;
  logic [nec_ir_pkg::TIME_W-1:0]  in_time;
  logic                           advance;

  nec_ir_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held edge moves into the core whenever the result register is free or is
  // being emptied by a transfer this cycle, so a pending result never blocks intake
  // for more than the cycles the consumer stalls.
  assign advance = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_time <= edge_time_us;
    end
  end

  nec_ir_frame_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .edge_time_us (in_time),
    .cfg          (cfg),
    .done         (core_done),
    .result       (core_result)
  );

  // Result register: loaded when the core completes a frame, cleared after its
  // transfer unless a new frame lands in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      address <= core_result.address;
      address_copy <= core_result.address_copy;
      command <= core_result.command;
      command_inverse <= core_result.command_inverse;
      frame_ok <= core_result.frame_ok;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("input stalled with an empty input register");

  a_result_retires: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !core_done) |=> !out_valid)
    else $error("result still valid after its transfer");

  a_done_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    core_done |-> (in_full && (!out_valid || !out_stall)))
    else $error("frame completed while the result register was blocked");

endmodule
